>>> rtl/wsdf_pkg.sv
// Shared types and helpers for the WebSocket frame deframer.
// Holds the parse phase encoding, the result record and the opcode classifier.
// No dependencies.
`timescale 1ns / 1ps

package wsdf_pkg;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_BINARY = 2'd2;
  localparam logic [1:0] KIND_CLOSE  = 2'd3;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT_BYTES16 = 4'd2;
  localparam logic [3:0] EXT_BYTES64 = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic        is_header;
    logic [1:0]  frame_kind;
    logic [3:0]  opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  function automatic logic [1:0] kind_of(input logic [3:0] op);
    logic [1:0] k;
    k = KIND_OTHER;
    if (op == OP_TEXT) k = KIND_TEXT;
    else if (op == OP_BINARY) k = KIND_BINARY;
    else if (op == OP_CLOSE) k = KIND_CLOSE;
    return k;
  endfunction

endpackage

>>> rtl/websocket_frame_deframer_top.sv
// WebSocket frame deframer (RFC 6455 receive framing), one byte per beat.
// One input byte is accepted in every cycle while the two-entry output buffer
// (result register plus skid register) has room; a header beat or payload beat
// is registered before it leaves. in_ready drops only when both output
// entries are full, so a stalled consumer costs no throughput until the skid
// entry is taken. Header bytes give no result until the last one, which emits
// a descriptor; payload bytes come out unmasked with the 4-byte key.
// Depends on wsdf_pkg.
`timescale 1ns / 1ps

module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_header,
  output logic [1:0]  out_frame_kind,
  output logic [3:0]  out_opcode_out,
  output logic        out_mask_present,
  output logic [63:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);

  wsdf_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]        hdr_idx_r, hdr_idx_nxt;
  logic [3:0]        opcode_r, opcode_nxt;
  logic              mask_r, mask_nxt;
  logic [3:0]        ext_size_r, ext_size_nxt;
  logic [63:0]       len_r, len_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [1:0]        key_idx_r, key_idx_nxt;
  logic [63:0]       remain_r, remain_nxt;

  wsdf_pkg::result_t out_r, skid_r, res;
  logic              out_vld_r, skid_vld_r;
  logic              res_vld;
  logic              in_fire;
  logic              hdr_done;
  logic [3:0]        idx_inc;
  logic [7:0]        key_byte;
  logic              fin;
  logic              out_load, skid_load, out_from_skid;

  assign in_ready = !skid_vld_r;
  assign in_fire  = in_valid && in_ready;
  assign idx_inc  = 4'(hdr_idx_r + 4'd1);
  assign fin      = (remain_r == 64'd1);

  always_comb begin
    unique case (key_idx_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      2'd3: key_byte = key_r[7:0];
      default: key_byte = key_r[31:24];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    ext_size_nxt = ext_size_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    key_idx_nxt  = key_idx_r;
    remain_nxt   = remain_r;
    hdr_done     = 1'b0;
    res_vld      = 1'b0;
    res          = '0;

    if (in_fire) begin
      if (in_frame_start) begin
        // a start byte always aborts whatever frame was in progress
        opcode_nxt   = in_data_byte[3:0];
        mask_nxt     = 1'b0;
        ext_size_nxt = '0;
        len_nxt      = '0;
        key_nxt      = '0;
        key_idx_nxt  = '0;
        remain_nxt   = '0;
        hdr_idx_nxt  = '0;
        phase_nxt    = wsdf_pkg::PH_LEN;
      end else begin
        unique case (phase_r)
          wsdf_pkg::PH_LEN: begin
            mask_nxt    = in_data_byte[7];
            hdr_idx_nxt = '0;
            len_nxt     = '0;
            if (in_data_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
              ext_size_nxt = wsdf_pkg::EXT_BYTES16;
              phase_nxt    = wsdf_pkg::PH_EXT;
            end else if (in_data_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
              ext_size_nxt = wsdf_pkg::EXT_BYTES64;
              phase_nxt    = wsdf_pkg::PH_EXT;
            end else begin
              ext_size_nxt = '0;
              len_nxt      = {57'd0, in_data_byte[6:0]};
              if (in_data_byte[7]) phase_nxt = wsdf_pkg::PH_KEY;
              else hdr_done = 1'b1;
            end
          end
          wsdf_pkg::PH_EXT: begin
            len_nxt     = {len_r[55:0], in_data_byte};
            hdr_idx_nxt = idx_inc;
            if (idx_inc >= ext_size_r) begin
              hdr_idx_nxt = '0;
              if (mask_r) phase_nxt = wsdf_pkg::PH_KEY;
              else hdr_done = 1'b1;
            end
          end
          wsdf_pkg::PH_KEY: begin
            key_nxt     = {key_r[23:0], in_data_byte};
            hdr_idx_nxt = idx_inc;
            if (idx_inc >= wsdf_pkg::KEY_BYTES) begin
              hdr_idx_nxt = '0;
              hdr_done    = 1'b1;
            end
          end
          wsdf_pkg::PH_PAYLOAD: begin
            res_vld            = 1'b1;
            res.is_header      = 1'b0;
            res.frame_kind     = wsdf_pkg::kind_of(opcode_r);
            res.opcode         = opcode_r;
            res.mask_present   = mask_r;
            res.payload_length = len_r;
            res.payload_byte   = mask_r ? (in_data_byte ^ key_byte) : in_data_byte;
            res.last           = fin;
            key_idx_nxt        = 2'(key_idx_r + 2'd1);
            remain_nxt         = remain_r - 64'd1;
            if (fin) phase_nxt = wsdf_pkg::PH_IDLE;
          end
          wsdf_pkg::PH_IDLE: begin
            // stray bytes outside a frame are dropped
          end
          default: phase_nxt = wsdf_pkg::PH_IDLE;
        endcase

        if (hdr_done) begin
          res_vld            = 1'b1;
          res.is_header      = 1'b1;
          res.frame_kind     = wsdf_pkg::kind_of(opcode_r);
          res.opcode         = opcode_r;
          res.mask_present   = mask_nxt;
          res.payload_length = len_nxt;
          res.payload_byte   = '0;
          res.last           = (len_nxt == 64'd0);
          key_idx_nxt        = '0;
          remain_nxt         = len_nxt;
          phase_nxt          = (len_nxt == 64'd0) ? wsdf_pkg::PH_IDLE
                                                  : wsdf_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  // res_vld implies the skid entry is empty (in_ready)
  assign skid_load     = res_vld && out_vld_r && !out_ready;
  assign out_load      = res_vld && !skid_load;
  assign out_from_skid = !res_vld && skid_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsdf_pkg::PH_IDLE;
      hdr_idx_r  <= '0;
      opcode_r   <= '0;
      mask_r     <= 1'b0;
      ext_size_r <= '0;
      len_r      <= '0;
      key_r      <= '0;
      key_idx_r  <= '0;
      remain_r   <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      ext_size_r <= ext_size_nxt;
      len_r      <= len_nxt;
      key_r      <= key_nxt;
      key_idx_r  <= key_idx_nxt;
      remain_r   <= remain_nxt;
      if (skid_load) begin
        skid_vld_r <= 1'b1;
      end else if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_ready) begin
        if (skid_vld_r) skid_vld_r <= 1'b0;
        else out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_load) skid_r <= res;
    if (out_load) out_r <= res;
    else if (out_from_skid) out_r <= skid_r;
  end

  assign out_valid          = out_vld_r;
  assign out_is_header      = out_r.is_header;
  assign out_frame_kind     = out_r.frame_kind;
  assign out_opcode_out     = out_r.opcode;
  assign out_mask_present   = out_r.mask_present;
  assign out_payload_length = out_r.payload_length;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_last           = out_r.last;

endmodule

>>> rtl/wsdf_checker.sv
// Port-level checks for the WebSocket frame deframer, plus the bind that
// attaches them to websocket_frame_deframer_top. Depends on wsdf_pkg.
`timescale 1ns / 1ps

module wsdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_header,
  input logic [1:0]  out_frame_kind,
  input logic [3:0]  out_opcode_out,
  input logic [63:0] out_payload_length,
  input logic [7:0]  out_payload_byte,
  input logic        out_last
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_is_header) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // header descriptor closes the frame exactly when the payload is empty
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> out_last == (out_payload_length == 64'd0))
    else $error("header last flag disagrees with length");

  a_hdr_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> out_payload_byte == 8'd0)
    else $error("header descriptor carries a payload byte");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_frame_kind == wsdf_pkg::KIND_TEXT) == (out_opcode_out == wsdf_pkg::OP_TEXT)
      && (out_frame_kind == wsdf_pkg::KIND_BINARY) == (out_opcode_out == wsdf_pkg::OP_BINARY)
      && (out_frame_kind == wsdf_pkg::KIND_CLOSE) == (out_opcode_out == wsdf_pkg::OP_CLOSE))
    else $error("frame kind does not match opcode");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_is_header     (out_is_header),
  .out_frame_kind    (out_frame_kind),
  .out_opcode_out    (out_opcode_out),
  .out_payload_length(out_payload_length),
  .out_payload_byte  (out_payload_byte),
  .out_last          (out_last)
);

>>> tb/sv/websocket_frame_deframer_top_tb.sv
// Self-checking testbench for websocket_frame_deframer_top: directed frames, then random
// frame streams checked beat by beat against a behavioral deframer kept in the bench.
// Depends on wsdf_pkg and the deframer RTL.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;

  localparam logic [3:0] OP_RSVD_CTRL = 4'hF;
  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES = 120;

  typedef enum {SRC_MODEL, SRC_NONE, SRC_TABLE} exp_src_t;

  typedef struct {
    logic [7:0]        data;
    bit                start;
    exp_src_t          src;
    wsdf_pkg::result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_header;
  logic [1:0]  out_frame_kind;
  logic [3:0]  out_opcode_out;
  logic        out_mask_present;
  logic [63:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic        out_last;

  websocket_frame_deframer_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_is_header(out_is_header), .out_frame_kind(out_frame_kind),
    .out_opcode_out(out_opcode_out), .out_mask_present(out_mask_present),
    .out_payload_length(out_payload_length), .out_payload_byte(out_payload_byte),
    .out_last(out_last)
  );

  always #2 clk = ~clk;

  // deframer state mirrored in the bench
  wsdf_pkg::phase_t df_phase = wsdf_pkg::PH_IDLE;
  logic [3:0]  df_idx = '0;
  logic [3:0]  df_op = '0;
  logic        df_mask = 1'b0;
  logic [3:0]  df_ext = '0;
  logic [63:0] df_len = '0;
  logic [31:0] df_key = '0;
  logic [63:0] df_cnt = '0;

  wsdf_pkg::result_t beats_due[$];
  stim_row_t dir_rows[$];

  int n_fails = 0;
  int n_items = 0;
  int n_ignored = 0;
  int n_beats = 0;
  int n_headers = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  function automatic logic [1:0] frame_class(input logic [3:0] op);
    case (op)
      wsdf_pkg::OP_TEXT:   return wsdf_pkg::KIND_TEXT;
      wsdf_pkg::OP_BINARY: return wsdf_pkg::KIND_BINARY;
      wsdf_pkg::OP_CLOSE:  return wsdf_pkg::KIND_CLOSE;
      default:             return wsdf_pkg::KIND_OTHER;
    endcase
  endfunction

  function automatic wsdf_pkg::result_t mk(input logic hdr, input logic [1:0] kind,
                                           input logic [3:0] op, input logic mask,
                                           input logic [63:0] len, input logic [7:0] pb,
                                           input logic lst);
    wsdf_pkg::result_t r;
    r.is_header = hdr;
    r.frame_kind = kind;
    r.opcode = op;
    r.mask_present = mask;
    r.payload_length = len;
    r.payload_byte = pb;
    r.last = lst;
    return r;
  endfunction

  function automatic wsdf_pkg::result_t header_done();
    logic empty;
    empty = (df_len == 64'd0);
    df_cnt = '0;
    df_phase = empty ? wsdf_pkg::PH_IDLE : wsdf_pkg::PH_PAYLOAD;
    return mk(1'b1, frame_class(df_op), df_op, df_mask, df_len, 8'h00, empty);
  endfunction

  // Advance the mirrored deframer by one byte; returns 1 when a beat is due.
  function automatic bit deframe_byte(input logic [7:0] b, input bit st,
                                      output wsdf_pkg::result_t r);
    logic [6:0] l7;
    logic [7:0] kb;
    logic fin;
    r = '0;
    if (st) begin
      df_op = b[3:0];
      df_mask = 1'b0;
      df_ext = '0;
      df_len = '0;
      df_key = '0;
      df_cnt = '0;
      df_idx = '0;
      df_phase = wsdf_pkg::PH_LEN;
      return 1'b0;
    end
    case (df_phase)
      wsdf_pkg::PH_LEN: begin
        l7 = b[6:0];
        df_mask = b[7];
        df_idx = '0;
        df_len = '0;
        if (l7 == wsdf_pkg::LEN_EXT16 || l7 == wsdf_pkg::LEN_EXT64) begin
          df_ext = (l7 == wsdf_pkg::LEN_EXT16) ? wsdf_pkg::EXT_BYTES16
                                               : wsdf_pkg::EXT_BYTES64;
          df_phase = wsdf_pkg::PH_EXT;
          return 1'b0;
        end
        df_ext = '0;
        df_len = {57'd0, l7};
        if (df_mask) begin
          df_phase = wsdf_pkg::PH_KEY;
          return 1'b0;
        end
        r = header_done();
        return 1'b1;
      end
      wsdf_pkg::PH_EXT: begin
        df_len = {df_len[55:0], b};
        df_idx = df_idx + 4'd1;
        if (df_idx < df_ext) return 1'b0;
        df_idx = '0;
        if (df_mask) begin
          df_phase = wsdf_pkg::PH_KEY;
          return 1'b0;
        end
        r = header_done();
        return 1'b1;
      end
      wsdf_pkg::PH_KEY: begin
        df_key = {df_key[23:0], b};
        df_idx = df_idx + 4'd1;
        if (df_idx < wsdf_pkg::KEY_BYTES) return 1'b0;
        df_idx = '0;
        r = header_done();
        return 1'b1;
      end
      wsdf_pkg::PH_PAYLOAD: begin
        // key bytes go out most significant first
        kb = df_mask ? 8'(df_key >> (24 - 8 * df_cnt[1:0])) : 8'h00;
        df_cnt = df_cnt + 64'd1;
        fin = (df_cnt == df_len);
        r = mk(1'b0, frame_class(df_op), df_op, df_mask, df_len, b ^ kb, fin);
        if (fin) df_phase = wsdf_pkg::PH_IDLE;
        return 1'b1;
      end
      default: begin
        df_phase = wsdf_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit st, input exp_src_t src,
                           input wsdf_pkg::result_t typed);
    wsdf_pkg::result_t r;
    bit got;
    bit ignored;
    // each idle cycle drawn on its own
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_frame_start <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ignored = !st && (df_phase == wsdf_pkg::PH_IDLE);
    got = deframe_byte(b, st, r);
    if (src == SRC_MODEL && got) beats_due.push_back(r);
    else if (src == SRC_TABLE) beats_due.push_back(typed);
    if (ignored) n_ignored++;
    else n_items++;
  endtask

  task automatic send_random_frame();
    logic [7:0] fr[$];
    logic [7:0] b0;
    logic [63:0] len;
    logic mask;
    int mode, lim, pay;
    b0 = 8'($urandom_range(255));
    case ($urandom_range(5))
      0: b0[3:0] = wsdf_pkg::OP_TEXT;
      1: b0[3:0] = wsdf_pkg::OP_BINARY;
      2: b0[3:0] = wsdf_pkg::OP_CLOSE;
      default: ;
    endcase
    fr.push_back(b0);
    mask = 1'($urandom_range(1));
    mode = int'($urandom_range(9));
    if (mode < 6) begin
      len = ($urandom_range(7) == 0) ? 64'($urandom_range(0, 125))
                                     : 64'($urandom_range(0, 12));
      fr.push_back({mask, len[6:0]});
    end else if (mode < 8) begin
      len = ($urandom_range(5) == 0) ? 64'($urandom_range(0, 16'hFFFF))
                                     : 64'($urandom_range(0, 24));
      fr.push_back({mask, wsdf_pkg::LEN_EXT16});
      fr.push_back(len[15:8]);
      fr.push_back(len[7:0]);
    end else begin
      len = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 24));
      fr.push_back({mask, wsdf_pkg::LEN_EXT64});
      for (int i = 7; i >= 0; i--) fr.push_back(len[8 * i +: 8]);
    end
    if (mask) repeat (4) fr.push_back(8'($urandom_range(255)));
    // huge lengths are cut short; the next start aborts them
    pay = (len > 64'd48) ? int'($urandom_range(0, 48)) : int'(len);
    repeat (pay) fr.push_back(8'($urandom_range(255)));
    lim = fr.size();
    if ($urandom_range(99) < 8) lim = int'($urandom_range(1, fr.size()));
    for (int i = 0; i < lim; i++) send_byte(fr[i], i == 0, SRC_MODEL, '0);
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0, SRC_MODEL, '0);
  endtask

  function automatic void cmp(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      n_fails++;
    end
  endfunction

  // result side: check accepted beats, then pick next ready
  always @(posedge clk) begin
    wsdf_pkg::result_t e;
    if (rst_n && out_valid && out_ready) begin
      n_beats++;
      if (beats_due.size() == 0) begin
        $error("result beat with nothing expected");
        n_fails++;
      end else begin
        e = beats_due.pop_front();
        if (e.is_header) n_headers++;
        cmp("is_header", 64'(e.is_header), 64'(out_is_header));
        cmp("frame_kind", 64'(e.frame_kind), 64'(out_frame_kind));
        cmp("opcode_out", 64'(e.opcode), 64'(out_opcode_out));
        cmp("mask_present", 64'(e.mask_present), 64'(out_mask_present));
        cmp("payload_length", e.payload_length, out_payload_length);
        cmp("payload_byte", 64'(e.payload_byte), 64'(out_payload_byte));
        cmp("last", 64'(e.last), 64'(out_last));
      end
    end
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("** websocket_frame_deframer_top: FAILED **");
    $finish;
  end

  initial begin
    int goal;
    // outside a frame, then a text frame with empty payload
    dir_rows.push_back('{8'hFF, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'h81, 1'b1, SRC_NONE, '0});
    dir_rows.push_back('{8'h00, 1'b0, SRC_TABLE,
                         mk(1'b1, wsdf_pkg::KIND_TEXT, wsdf_pkg::OP_TEXT, 1'b0, 64'd0,
                            8'h00, 1'b1)});
    // masked binary frame, two payload bytes
    dir_rows.push_back('{8'h82, 1'b1, SRC_NONE, '0});
    dir_rows.push_back('{8'h82, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'h12, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'h34, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'h56, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'h78, 1'b0, SRC_TABLE,
                         mk(1'b1, wsdf_pkg::KIND_BINARY, wsdf_pkg::OP_BINARY, 1'b1, 64'd2,
                            8'h00, 1'b0)});
    dir_rows.push_back('{8'hFF, 1'b0, SRC_TABLE,
                         mk(1'b0, wsdf_pkg::KIND_BINARY, wsdf_pkg::OP_BINARY, 1'b1, 64'd2,
                            8'hED, 1'b0)});
    dir_rows.push_back('{8'hA5, 1'b0, SRC_MODEL, '0});
    // close with max 16-bit length, left unfinished
    dir_rows.push_back('{8'h88, 1'b1, SRC_NONE, '0});
    dir_rows.push_back('{8'h7E, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'hFF, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'hFF, 1'b0, SRC_TABLE,
                         mk(1'b1, wsdf_pkg::KIND_CLOSE, wsdf_pkg::OP_CLOSE, 1'b0, 64'hFFFF,
                            8'h00, 1'b0)});
    // start inside a frame aborts it; all-ones 64-bit length
    dir_rows.push_back('{8'h7F, 1'b1, SRC_NONE, '0});
    dir_rows.push_back('{8'h7F, 1'b0, SRC_NONE, '0});
    repeat (7) dir_rows.push_back('{8'hFF, 1'b0, SRC_NONE, '0});
    dir_rows.push_back('{8'hFF, 1'b0, SRC_TABLE,
                         mk(1'b1, wsdf_pkg::KIND_OTHER, OP_RSVD_CTRL, 1'b0, '1,
                            8'h00, 1'b0)});

    send_idle_pct = 19;
    recv_idle_pct <= 82;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].start,
                                    dir_rows[i].src, dir_rows[i].res);

    goal = n_items + RANDOM_ITEMS / 3;
    while (n_items < goal) send_random_frame();

    send_idle_pct = 82;
    recv_idle_pct <= 19;
    goal = n_items + RANDOM_ITEMS / 3;
    while (n_items < goal) send_random_frame();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    goal = n_items + RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3);
    while (n_items < goal) send_random_frame();

    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d frame bytes plus %0d stray bytes; checked %0d result beats",
             n_items, n_ignored, n_beats);
    $display("(%0d headers). Idle mixes: sender-light, reversed, none; one %0d-cycle stall.",
             n_headers, HOLD_CYCLES);
    if (n_fails == 0) begin
      $display("** websocket_frame_deframer_top: PASSED **");
    end else begin
      $display("** websocket_frame_deframer_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> websocket_frame_deframer_top.f
rtl/wsdf_pkg.sv
rtl/websocket_frame_deframer_top.sv
rtl/wsdf_checker.sv
tb/sv/websocket_frame_deframer_top_tb.sv
